/* sv/mcbk_pkg.sv */
// Shared types, constants and Morse lookup functions for the beacon keyer.
package mcbk_pkg;

  localparam int MAX_CHARS_DEF = 16;
  localparam int MAX_MARKS_DEF = 6;
  localparam int MAX_MARKS_HI  = 8;
  localparam int PATTERN_LEN   = 5;

  localparam int CHAR_W     = 8;
  localparam int POS_W      = 5;
  localparam int MPOS_W     = 3;
  localparam int UNIT_W     = 3;
  localparam int TICK_W     = 8;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int CHARS_W    = 64;
  localparam int LETTERS    = 26;

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(16);

  localparam logic [UNIT_W-1:0] UNITS_WORD_GAP = UNIT_W'(7);
  localparam logic [UNIT_W-1:0] UNITS_CHAR_GAP = UNIT_W'(3);
  localparam logic [UNIT_W-1:0] UNITS_MARK_GAP = UNIT_W'(1);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_Z_UP  = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_Z_LO  = 8'h7a;

  typedef logic [1:0] mark_len_t;
  typedef mark_len_t [PATTERN_LEN-1:0] pattern_t;
  typedef mark_len_t [MAX_MARKS_HI-1:0] pattern_wide_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_CHARS_LOW  = 3'd1,
    REG_CHARS_HIGH = 3'd2,
    REG_CHAR_COUNT = 3'd3,
    REG_DIT_TICKS  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic     hit;
    pattern_t marks;
  } decode_t;

  typedef struct packed {
    logic               enable;
    logic [CHARS_W-1:0] chars_low;
    logic [CHARS_W-1:0] chars_high;
    logic [POS_W-1:0]   limit;
    logic [TICK_W-1:0]  dit_ticks;
  } cfg_t;

  typedef struct packed {
    logic     strobe;
    pattern_t marks;
  } load_t;

  function automatic pattern_t mk(input mark_len_t m0, input mark_len_t m1,
                                  input mark_len_t m2, input mark_len_t m3,
                                  input mark_len_t m4);
    pattern_t p;
    p[0] = m0;
    p[1] = m1;
    p[2] = m2;
    p[3] = m3;
    p[4] = m4;
    return p;
  endfunction

  // Mark lengths in units (1 = dit, 3 = dah, 0 = no further mark).
  function automatic pattern_t code_lookup(input logic [5:0] idx);
    pattern_t p;
    case (idx)
      6'd0:  p = mk(1, 3, 0, 0, 0);
      6'd1:  p = mk(3, 1, 1, 1, 0);
      6'd2:  p = mk(3, 1, 3, 1, 0);
      6'd3:  p = mk(3, 1, 1, 0, 0);
      6'd4:  p = mk(1, 0, 0, 0, 0);
      6'd5:  p = mk(1, 1, 3, 1, 0);
      6'd6:  p = mk(3, 3, 1, 0, 0);
      6'd7:  p = mk(1, 1, 1, 1, 0);
      6'd8:  p = mk(1, 1, 0, 0, 0);
      6'd9:  p = mk(1, 3, 3, 3, 0);
      6'd10: p = mk(3, 1, 3, 0, 0);
      6'd11: p = mk(1, 3, 1, 1, 0);
      6'd12: p = mk(3, 3, 0, 0, 0);
      6'd13: p = mk(3, 1, 0, 0, 0);
      6'd14: p = mk(3, 3, 3, 0, 0);
      6'd15: p = mk(1, 3, 3, 1, 0);
      6'd16: p = mk(3, 3, 1, 3, 0);
      6'd17: p = mk(1, 3, 1, 0, 0);
      6'd18: p = mk(1, 1, 1, 0, 0);
      6'd19: p = mk(3, 0, 0, 0, 0);
      6'd20: p = mk(1, 1, 3, 0, 0);
      6'd21: p = mk(1, 1, 1, 3, 0);
      6'd22: p = mk(1, 3, 3, 0, 0);
      6'd23: p = mk(3, 1, 1, 3, 0);
      6'd24: p = mk(3, 1, 3, 3, 0);
      6'd25: p = mk(3, 3, 1, 1, 0);
      6'd26: p = mk(3, 3, 3, 3, 3);
      6'd27: p = mk(1, 3, 3, 3, 3);
      6'd28: p = mk(1, 1, 3, 3, 3);
      6'd29: p = mk(1, 1, 1, 3, 3);
      6'd30: p = mk(1, 1, 1, 1, 3);
      6'd31: p = mk(1, 1, 1, 1, 1);
      6'd32: p = mk(3, 1, 1, 1, 1);
      6'd33: p = mk(3, 3, 1, 1, 1);
      6'd34: p = mk(3, 3, 3, 1, 1);
      6'd35: p = mk(3, 3, 3, 3, 1);
      default: p = '0;
    endcase
    return p;
  endfunction

  // Letters of either case and digits hit; every other byte misses.
  function automatic decode_t decode_char(input logic [CHAR_W-1:0] c);
    decode_t          d;
    logic [CHAR_W-1:0] ofs;
    d.hit = 1'b1;
    if (c >= CH_A_LO && c <= CH_Z_LO) begin
      ofs = c - CH_A_LO;
    end else if (c >= CH_A_UP && c <= CH_Z_UP) begin
      ofs = c - CH_A_UP;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      ofs = c - CH_ZERO + CHAR_W'(LETTERS);
    end else begin
      ofs   = '0;
      d.hit = 1'b0;
    end
    d.marks = code_lookup(ofs[5:0]);
    return d;
  endfunction

  // Positions at or past the valid length read as NUL.
  function automatic logic [CHAR_W-1:0] read_char(input logic [CHARS_W-1:0] lo,
                                                  input logic [CHARS_W-1:0] hi,
                                                  input logic [POS_W-1:0]   limit,
                                                  input logic [POS_W-1:0]   p);
    logic [2*CHARS_W-1:0] all_chars;
    all_chars = {hi, lo};
    if (p >= limit || p[POS_W-1]) begin
      return CH_NUL;
    end
    return all_chars[{p[POS_W-2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

/* sv/mcbk_if.sv */
// Handshake channel interfaces for the tick, result and configuration ports.
interface mcbk_in_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface mcbk_out_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic keyed;
  modport source (output valid, output pin_level, output keyed, input ready);
  modport sink (input valid, input pin_level, input keyed, output ready);
endinterface

interface mcbk_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mcbk_pkg::REG_IDX_W-1:0]     index;
  logic [mcbk_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/morse_callsign_beacon_keyer.sv */
// Top level of the Morse callsign beacon keyer.
// The keyer sends a stored callsign of up to MAX_CHARS characters as a
// repeating Morse beacon. Each input item is one timer tick; every accepted
// item yields exactly one result item carrying the pin level and the keyed
// flag after that tick. Items are accepted in every clock cycle: the tick is
// applied to the sequencer state and the result is captured in an output
// register in the same cycle, where it is held until taken, and in_ch.ready
// drops only while a finished result waits and the sink holds out_ch.ready
// low. The rate is set by the single result register; the state update
// between it and the input is one short pass through the Morse table.
// A Morse unit lasts dit_ticks+1 ticks; a dit is one unit, a dah three,
// marks are one unit apart, characters three, and a space or the end of the
// callsign gives seven units before the text repeats. While a mark is keyed
// the pin toggles every tick to make a tone, between marks it is held low.
// Lower-case letters key like upper-case ones, and any byte that is not a
// letter or digit sends the previous pattern again. Writing enable with bit 0
// set also loads the first character's pattern if it is a letter or digit;
// configuration should be written only while no item is in flight. The
// configuration port is always ready and takes one register write per cycle.
module morse_callsign_beacon_keyer #(
  parameter int MAX_CHARS = mcbk_pkg::MAX_CHARS_DEF,
  parameter int MAX_MARKS = mcbk_pkg::MAX_MARKS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  mcbk_in_if.sink      in_ch,
  mcbk_out_if.source   out_ch,
  mcbk_cfg_if.sink     cfg_ch
);

  // Register values and the derived valid length, shared with the sequencer.
  mcbk_pkg::cfg_t  cfg_state;
  // Pattern load raised by an enable write.
  mcbk_pkg::load_t cfg_load;

  mcbk_cfg #(
    .MAX_CHARS (MAX_CHARS)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_ch),
    .cfg_o  (cfg_state),
    .load_o (cfg_load)
  );

  // The sequencer owns all beacon timing state and the result register.
  mcbk_seq #(
    .MAX_MARKS (MAX_MARKS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_i  (cfg_state),
    .load_i (cfg_load)
  );

endmodule

/* sv/mcbk_cfg.sv */
// Configuration register file and first-character pattern load strobe.
module mcbk_cfg #(
  parameter int MAX_CHARS = mcbk_pkg::MAX_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mcbk_cfg_if.sink          cfg,
  output mcbk_pkg::cfg_t    cfg_o,
  output mcbk_pkg::load_t   load_o
);

  localparam logic [mcbk_pkg::POS_W-1:0] CHAR_CAP = mcbk_pkg::POS_W'(MAX_CHARS);

  logic                               enable_r, enable_nxt;
  logic [mcbk_pkg::CHARS_W-1:0]       chars_low_r, chars_low_nxt;
  logic [mcbk_pkg::CHARS_W-1:0]       chars_high_r, chars_high_nxt;
  logic [mcbk_pkg::POS_W-1:0]         char_count_r, char_count_nxt;
  logic [mcbk_pkg::TICK_W-1:0]        dit_ticks_r, dit_ticks_nxt;
  logic                               write;
  logic [mcbk_pkg::POS_W-1:0]         limit;
  mcbk_pkg::decode_t                  first_dec;

  assign cfg.ready = 1'b1;
  assign write     = cfg.valid && cfg.ready;
  assign limit     = (char_count_r < CHAR_CAP) ? char_count_r : CHAR_CAP;

  always_comb begin
    enable_nxt     = enable_r;
    chars_low_nxt  = chars_low_r;
    chars_high_nxt = chars_high_r;
    char_count_nxt = char_count_r;
    dit_ticks_nxt  = dit_ticks_r;
    if (write) begin
      unique case (mcbk_pkg::reg_idx_t'(cfg.index))
        mcbk_pkg::REG_ENABLE:     enable_nxt = cfg.data[0];
        mcbk_pkg::REG_CHARS_LOW:  chars_low_nxt = cfg.data;
        mcbk_pkg::REG_CHARS_HIGH: chars_high_nxt = cfg.data;
        mcbk_pkg::REG_CHAR_COUNT: char_count_nxt = cfg.data[mcbk_pkg::POS_W-1:0];
        mcbk_pkg::REG_DIT_TICKS:  dit_ticks_nxt = cfg.data[mcbk_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Setting enable also loads the pattern of the first character if it is a letter or digit.
  assign first_dec = mcbk_pkg::decode_char(
      mcbk_pkg::read_char(chars_low_r, chars_high_r, limit, '0));
  assign load_o.strobe = write && (cfg.index == mcbk_pkg::REG_ENABLE) && cfg.data[0]
                         && first_dec.hit;
  assign load_o.marks  = first_dec.marks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      chars_low_r  <= '0;
      chars_high_r <= '0;
      char_count_r <= '0;
      dit_ticks_r  <= '0;
    end else begin
      enable_r     <= enable_nxt;
      chars_low_r  <= chars_low_nxt;
      chars_high_r <= chars_high_nxt;
      char_count_r <= char_count_nxt;
      dit_ticks_r  <= dit_ticks_nxt;
    end
  end

  assign cfg_o.enable     = enable_r;
  assign cfg_o.chars_low  = chars_low_r;
  assign cfg_o.chars_high = chars_high_r;
  assign cfg_o.limit      = limit;
  assign cfg_o.dit_ticks  = dit_ticks_r;

endmodule

/* sv/mcbk_seq.sv */
// Keying sequencer: per-tick state update and the registered result stage.
module mcbk_seq #(
  parameter int MAX_MARKS = mcbk_pkg::MAX_MARKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  mcbk_in_if.sink           in_ch,
  mcbk_out_if.source        out_ch,
  input  mcbk_pkg::cfg_t    cfg_i,
  input  mcbk_pkg::load_t   load_i
);

  localparam int MIDX_W = $clog2(MAX_MARKS);
  localparam logic [mcbk_pkg::MPOS_W:0] MARK_CAP = (mcbk_pkg::MPOS_W + 1)'(MAX_MARKS);

  logic [mcbk_pkg::POS_W-1:0]  char_pos_r, char_pos_nxt;
  logic [mcbk_pkg::MPOS_W-1:0] mark_pos_r, mark_pos_nxt;
  mcbk_pkg::mark_len_t         mark_lengths_r [MAX_MARKS];
  mcbk_pkg::mark_len_t         mark_lengths_nxt [MAX_MARKS];
  logic                        signal_active_r, signal_active_nxt;
  logic [mcbk_pkg::UNIT_W-1:0] units_left_r, units_left_nxt;
  logic [mcbk_pkg::TICK_W-1:0] tick_count_r, tick_count_nxt;
  logic                        pin_state_r, pin_state_nxt;

  logic                        out_valid_r;
  logic                        out_pin_level_r;
  logic                        out_keyed_r;

  logic                        accept;
  logic                        step;
  logic [mcbk_pkg::MPOS_W-1:0] mark_pos_inc;
  mcbk_pkg::mark_len_t         mark_cur;
  mcbk_pkg::mark_len_t         mark_next;
  logic [mcbk_pkg::POS_W-1:0]  pos_inc;
  logic [mcbk_pkg::POS_W-1:0]  pos_skip;
  logic [mcbk_pkg::POS_W-1:0]  pos_sel;
  logic [mcbk_pkg::CHAR_W-1:0] char_inc;
  mcbk_pkg::decode_t           next_dec;
  mcbk_pkg::pattern_wide_t     step_wide;
  mcbk_pkg::pattern_wide_t     load_wide;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign step        = accept && cfg_i.enable && in_ch.tick;

  assign mark_pos_inc = mark_pos_r + 1'b1;
  assign mark_cur  = ({1'b0, mark_pos_r} < MARK_CAP) ?
                     mark_lengths_r[mark_pos_r[MIDX_W-1:0]] : '0;
  assign mark_next = ({1'b0, mark_pos_inc} < MARK_CAP) ?
                     mark_lengths_r[mark_pos_inc[MIDX_W-1:0]] : '0;

  // Character after the current one, and where the sequencer lands after it.
  assign pos_inc  = char_pos_r + 1'b1;
  assign pos_skip = pos_inc + 1'b1;
  assign char_inc = mcbk_pkg::read_char(cfg_i.chars_low, cfg_i.chars_high,
                                        cfg_i.limit, pos_inc);
  assign pos_sel  = (char_inc == mcbk_pkg::CH_NUL)   ? '0 :
                    (char_inc == mcbk_pkg::CH_SPACE) ? pos_skip : pos_inc;
  assign next_dec = mcbk_pkg::decode_char(
      mcbk_pkg::read_char(cfg_i.chars_low, cfg_i.chars_high, cfg_i.limit, pos_sel));

  assign step_wide = (2 * mcbk_pkg::MAX_MARKS_HI)'(next_dec.marks);
  assign load_wide = (2 * mcbk_pkg::MAX_MARKS_HI)'(load_i.marks);

  always_comb begin
    char_pos_nxt      = char_pos_r;
    mark_pos_nxt      = mark_pos_r;
    mark_lengths_nxt  = mark_lengths_r;
    signal_active_nxt = signal_active_r;
    units_left_nxt    = units_left_r;
    tick_count_nxt    = tick_count_r;
    pin_state_nxt     = pin_state_r;
    if (step) begin
      if (units_left_r == '0) begin
        if (signal_active_r) begin
          signal_active_nxt = 1'b0;
          mark_pos_nxt      = mark_pos_inc;
          if (mark_next == '0) begin
            mark_pos_nxt = '0;
            char_pos_nxt = pos_sel;
            if (char_inc == mcbk_pkg::CH_NUL || char_inc == mcbk_pkg::CH_SPACE) begin
              units_left_nxt = mcbk_pkg::UNITS_WORD_GAP;
            end else begin
              units_left_nxt = mcbk_pkg::UNITS_CHAR_GAP;
            end
            if (next_dec.hit) begin
              for (int k = 0; k < MAX_MARKS; k++) begin
                mark_lengths_nxt[k] = step_wide[k];
              end
            end
          end else begin
            units_left_nxt = mcbk_pkg::UNITS_MARK_GAP;
          end
        end else begin
          signal_active_nxt = 1'b1;
          units_left_nxt    = mcbk_pkg::UNIT_W'(mark_cur);
        end
      end
      if (tick_count_r == cfg_i.dit_ticks) begin
        if (units_left_nxt != '0) begin
          units_left_nxt = units_left_nxt - 1'b1;
        end
        tick_count_nxt = '0;
      end else begin
        tick_count_nxt = tick_count_r + 1'b1;
      end
      pin_state_nxt = signal_active_nxt ? !pin_state_r : 1'b0;
    end
    if (load_i.strobe) begin
      for (int k = 0; k < MAX_MARKS; k++) begin
        mark_lengths_nxt[k] = load_wide[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_pos_r      <= '0;
      mark_pos_r      <= '0;
      mark_lengths_r  <= '{default: '0};
      signal_active_r <= 1'b0;
      units_left_r    <= '0;
      tick_count_r    <= '0;
      pin_state_r     <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      char_pos_r      <= char_pos_nxt;
      mark_pos_r      <= mark_pos_nxt;
      mark_lengths_r  <= mark_lengths_nxt;
      signal_active_r <= signal_active_nxt;
      units_left_r    <= units_left_nxt;
      tick_count_r    <= tick_count_nxt;
      pin_state_r     <= pin_state_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pin_level_r <= pin_state_nxt;
      out_keyed_r     <= cfg_i.enable && signal_active_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pin_level = out_pin_level_r;
  assign out_ch.keyed     = out_keyed_r;

`ifndef SYNTHESIS
  a_pin_only_in_mark: assert property (@(posedge clk) disable iff (!rst_n)
      pin_state_r |-> signal_active_r)
    else $error("pin high outside a mark");

  a_char_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
      char_pos_r <= mcbk_pkg::POS_LIMIT)
    else $error("character position past the callsign");

  a_mark_pos_holds: assert property (@(posedge clk) disable iff (!rst_n)
      (step && units_left_r != '0) |=> $stable(mark_pos_r) && $stable(char_pos_r))
    else $error("mark position moved inside a unit run");

  a_disabled_frozen: assert property (@(posedge clk) disable iff (!rst_n)
      (accept && !cfg_i.enable) |=> $stable(tick_count_r) && $stable(units_left_r))
    else $error("state advanced while disabled");

  a_keyed_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && out_keyed_r) |-> signal_active_r)
    else $error("keyed result without an active mark");
`endif

endmodule

/* tb/morse_callsign_beacon_keyer_test.sv */
// Self-checking testbench for the Morse callsign beacon keyer: directed table, then random beacons.
module morse_callsign_beacon_keyer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcbk_pkg::*;

  // One result item as the keyer reports it after a tick.
  typedef struct packed {
    logic pin_level;
    logic keyed;
  } beacon_out_t;

  // A directed row either writes one register or sends a run of ticks.
  typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [63:0] data;
    logic        tick;
    logic [7:0]  reps;
    logic        typed;
    logic        pin_level;
    logic        keyed;
  } plan_row_t;

  localparam int PLAN_ROWS    = 24;
  localparam int RANDOM_TICKS = 1550;

  // Directed table. Rows marked typed carry an expectation that can be read
  // straight off the behavior; all other tick rows are checked against the
  // beacon predictor below.
  plan_row_t plan [PLAN_ROWS] = '{
    // Straight out of reset the beacon is off: pin low, key up, with or
    // without a tick.
    '{ROW_TICK,  REG_ENABLE,     64'd0, 1'b1, 8'd1, 1'b1, 1'b0, 1'b0},
    '{ROW_TICK,  REG_ENABLE,     64'd0, 1'b0, 8'd1, 1'b1, 1'b0, 1'b0},
    // Empty callsign: enabling loads nothing, so every mark length is zero.
    // The first tick still keys the pin; the empty mark ends on the next one.
    '{ROW_WRITE, REG_CHAR_COUNT, 64'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_DIT_TICKS,  64'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_ENABLE,     64'd1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_ENABLE,     64'd0, 1'b1, 8'd1, 1'b1, 1'b1, 1'b1},
    '{ROW_TICK,  REG_ENABLE,     64'd0, 1'b1, 8'd3, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_ENABLE,     64'd0, 1'b0, 8'd1, 1'b0, 1'b0, 1'b0},
    // Lower-case "e", a space, then the end of a two-character callsign:
    // the sequencer lands on the position after the space, which reads as the end.
    '{ROW_WRITE, REG_CHARS_LOW,  64'h5A2065, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_CHAR_COUNT, 64'd2, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_ENABLE,     64'd1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_ENABLE,     64'd0, 1'b1, 8'd5, 1'b0, 1'b0, 1'b0},
    // Longest unit, then a shorter one below the running tick count so the
    // counter has to wrap through its top value.
    '{ROW_WRITE, REG_DIT_TICKS,  64'd255, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_ENABLE,     64'd0, 1'b1, 8'd3, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_DIT_TICKS,  64'd1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_ENABLE,     64'd0, 1'b1, 8'd3, 1'b0, 1'b0, 1'b0},
    // Disabled: state freezes and the pin holds its last level.
    '{ROW_WRITE, REG_ENABLE,     64'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_ENABLE,     64'd0, 1'b1, 8'd2, 1'b0, 1'b0, 1'b0},
    // Full sixteen characters with letters of both cases, digits, a space,
    // punctuation and 0xFF; a count above sixteen acts as sixteen.
    '{ROW_WRITE, REG_CHARS_HIGH, 64'h2F60_5B23_3039_417A, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_CHARS_LOW,  64'h3120_FF3A_5A40_7B61, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_CHAR_COUNT, 64'd31, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_DIT_TICKS,  64'd0, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_WRITE, REG_ENABLE,     64'd1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0},
    '{ROW_TICK,  REG_ENABLE,     64'd0, 1'b1, 8'd6, 1'b0, 1'b0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  mcbk_in_if  in_ch ();
  mcbk_out_if out_ch ();
  mcbk_cfg_if cfg_ch ();

  morse_callsign_beacon_keyer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the keyer's registers.
  bit         beacon_on;
  bit [63:0]  text_low;
  bit [63:0]  text_high;
  bit [4:0]   text_len;
  bit [7:0]   unit_ticks;

  // Shadow copy of the keyer's sequencer state.
  bit [4:0]   char_pos;
  bit [2:0]   mark_pos;
  bit [1:0]   marks [MAX_MARKS_DEF];
  bit         key_down;
  bit [2:0]   units_left;
  bit [7:0]   tick_count;
  bit         pin_state;

  // Expected pin and key levels, oldest first.
  beacon_out_t expected_levels [$];

  int send_idle_pct;
  int recv_idle_pct;
  int failures;
  int ticks_sent;
  int still_ticks;
  int results_seen;
  int keyed_seen;
  int reg_writes;

  // Marks of each letter and digit, written as unit counts: 1 is a dit,
  // 3 a dah.
  function automatic string morse_code_of(input int idx);
    case (idx)
      0:  return "13";    1:  return "3111";  2:  return "3131";  3:  return "311";
      4:  return "1";     5:  return "1131";  6:  return "331";   7:  return "1111";
      8:  return "11";    9:  return "1333";  10: return "313";   11: return "1311";
      12: return "33";    13: return "31";    14: return "333";   15: return "1331";
      16: return "3313";  17: return "131";   18: return "111";   19: return "3";
      20: return "113";   21: return "1113";  22: return "133";   23: return "3113";
      24: return "3133";  25: return "3311";
      26: return "33333"; 27: return "13333"; 28: return "11333"; 29: return "11133";
      30: return "11113"; 31: return "11111"; 32: return "31111"; 33: return "33111";
      34: return "33311"; 35: return "33331";
      default: return "";
    endcase
  endfunction

  // Character at a callsign position; anything past the valid length is NUL.
  function automatic bit [7:0] callsign_byte(input bit [4:0] p);
    bit [127:0]  text;
    int unsigned lim;
    text = {text_high, text_low};
    lim  = (text_len < MAX_CHARS_DEF) ? text_len : MAX_CHARS_DEF;
    if (p >= lim) return CH_NUL;
    return text[8*p +: 8];
  endfunction

  // Letters and digits replace the mark pattern; any other byte keeps the
  // previous one so it is sent again.
  function automatic void load_marks(input bit [7:0] c);
    int    idx;
    string code;
    if (c >= CH_A_LO && c <= CH_Z_LO) idx = c - CH_A_LO;
    else if (c >= CH_A_UP && c <= CH_Z_UP) idx = c - CH_A_UP;
    else if (c >= CH_ZERO && c <= CH_NINE) idx = c - CH_ZERO + LETTERS;
    else return;
    code = morse_code_of(idx);
    foreach (marks[k]) marks[k] = (k < code.len()) ? 2'(code[k] - CH_ZERO) : 2'd0;
  endfunction

  function automatic bit [2:0] mark_len(input bit [2:0] p);
    return (p < MAX_MARKS_DEF) ? 3'(marks[p]) : 3'd0;
  endfunction

  function automatic void apply_reg(input reg_idx_t idx, input bit [63:0] v);
    case (idx)
      REG_ENABLE: begin
        beacon_on = v[0];
        if (beacon_on) load_marks(callsign_byte(5'd0));
      end
      REG_CHARS_LOW:  text_low   = v;
      REG_CHARS_HIGH: text_high  = v;
      REG_CHAR_COUNT: text_len   = v[4:0];
      REG_DIT_TICKS:  unit_ticks = v[7:0];
      default: ;
    endcase
  endfunction

  // Advances the shadow beacon by one tick item and returns the pin and key
  // levels that the keyer must report for it.
  function automatic beacon_out_t advance_tick(input bit t);
    beacon_out_t res;
    bit [7:0]    c;
    if (beacon_on && t) begin
      if (units_left == 0) begin
        if (key_down) begin
          // End of a mark: either the next mark follows after one unit, or
          // the character is done and the gap depends on what comes next.
          key_down = 1'b0;
          mark_pos = mark_pos + 3'd1;
          if (mark_len(mark_pos) == 0) begin
            char_pos = char_pos + 5'd1;
            mark_pos = '0;
            c = callsign_byte(char_pos);
            if (c == CH_NUL) begin
              char_pos   = '0;
              units_left = UNITS_WORD_GAP;
            end else if (c == CH_SPACE) begin
              char_pos   = char_pos + 5'd1;
              units_left = UNITS_WORD_GAP;
            end else begin
              units_left = UNITS_CHAR_GAP;
            end
            load_marks(callsign_byte(char_pos));
          end else begin
            units_left = UNITS_MARK_GAP;
          end
        end else begin
          key_down   = 1'b1;
          units_left = mark_len(mark_pos);
        end
      end
      if (tick_count == unit_ticks) begin
        if (units_left != 0) units_left = units_left - 3'd1;
        tick_count = '0;
      end else begin
        tick_count = tick_count + 8'd1;
      end
      pin_state = key_down ? ~pin_state : 1'b0;
    end
    res.pin_level = pin_state;
    res.keyed     = beacon_on & key_down;
    return res;
  endfunction

  // Mostly letters of either case and digits, some spaces, and some bytes
  // of any value.
  function automatic bit [7:0] random_callsign_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return CH_A_UP + 8'($urandom_range(25));
    if (r < 60) return CH_A_LO + 8'($urandom_range(25));
    if (r < 80) return CH_ZERO + 8'($urandom_range(9));
    if (r < 90) return CH_SPACE;
    return 8'($urandom_range(255));
  endfunction

  // Register writes happen only once every expected result has come back,
  // plus a short pause behind the result register.
  task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, v);
    reg_writes++;
  endtask

  // Sends one tick item, with an optional random gap before it. The valid
  // line is lowered only when a gap is taken, so back-to-back items keep it
  // high without a glitch.
  task automatic send_tick(input bit t, input bit typed, input beacon_out_t typed_out);
    beacon_out_t predicted;
    cfg_ch.valid <= 1'b0;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.tick  <= t;
    do @(posedge clk); while (!in_ch.ready);
    predicted = advance_tick(t);
    expected_levels.push_back(typed ? typed_out : predicted);
    ticks_sent++;
    if (!t) still_ticks++;
  endtask

  // The receiver stalls at the rate chosen for the current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin
    beacon_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.keyed) keyed_seen++;
      if (expected_levels.size() == 0) begin
        $error("result item arrived with no expectation pending");
        failures++;
      end else begin
        want = expected_levels.pop_front();
        if (out_ch.pin_level !== want.pin_level) begin
          $error("pin_level mismatch: expected %0b, actual %0b",
                 want.pin_level, out_ch.pin_level);
          failures++;
        end
        if (out_ch.keyed !== want.keyed) begin
          $error("keyed mismatch: expected %0b, actual %0b", want.keyed, out_ch.keyed);
          failures++;
        end
      end
    end
  end

  initial begin
    bit [127:0]  text;
    logic [63:0] junk;
    int          r;
    int          random_ticks;
    int          seg_len;
    bit          full;
    bit [4:0]    count_val;
    bit [7:0]    dit_val;

    in_ch.valid   = 1'b0;
    in_ch.tick    = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_ENABLE;
    cfg_ch.data   = '0;
    rst_n         = 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 75;
    random_ticks  = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: walk the table row by row.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        repeat (plan[i].reps)
          send_tick(plan[i].tick, plan[i].typed, '{plan[i].pin_level, plan[i].keyed});
      end
    end

    // Random part: short beacon segments, each after a new configuration.
    // The first third idles mostly on the receive side, the second mostly on
    // the send side, and the last third runs at full rate.
    while (random_ticks < RANDOM_TICKS) begin
      case (random_ticks * 3 / RANDOM_TICKS)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 75;
        end
        1: begin
          send_idle_pct = 75;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      // Most segments load a fresh callsign; the rest retune the unit length and
      // may also rewrite enable; a retune may leave the tick counter above the new limit.
      full = ($urandom_range(99) < 75);
      if (full) begin
        for (int k = 0; k < 16; k++) text[8*k +: 8] = random_callsign_char();
        write_reg(REG_CHARS_LOW, text[63:0]);
        write_reg(REG_CHARS_HIGH, text[127:64]);
        r = $urandom_range(99);
        if (r < 60) count_val = 5'($urandom_range(1, 6));
        else if (r < 85) count_val = 5'($urandom_range(7, 16));
        else if (r < 92) count_val = 5'd0;
        else count_val = 5'($urandom_range(17, 31));
        junk = {$urandom, $urandom};
        junk[4:0] = count_val;
        write_reg(REG_CHAR_COUNT, junk);
      end
      r = $urandom_range(99);
      if (r < 65) dit_val = 8'd0;
      else if (r < 85) dit_val = 8'($urandom_range(1, 3));
      else if (r < 97) dit_val = 8'($urandom_range(4, 12));
      else dit_val = 8'd255;
      junk = {$urandom, $urandom};
      junk[7:0] = dit_val;
      write_reg(REG_DIT_TICKS, junk);
      if (full || $urandom_range(99) < 50) begin
        junk = {$urandom, $urandom};
        junk[0] = ($urandom_range(99) < 90);
        write_reg(REG_ENABLE, junk);
      end

      seg_len = $urandom_range(30, 120);
      if (seg_len > RANDOM_TICKS - random_ticks) seg_len = RANDOM_TICKS - random_ticks;
      repeat (seg_len) begin
        send_tick($urandom_range(99) < 92, 1'b0, '0);
        random_ticks++;
      end
    end

    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Summary: %0d tick items sent (%0d of them without advancing time), %0d register writes.",
             ticks_sent, still_ticks, reg_writes);
    $display("Summary: %0d result items checked, %0d of them with the key down.",
             results_seen, keyed_seen);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
sv/mcbk_pkg.sv
sv/mcbk_if.sv
sv/mcbk_cfg.sv
sv/mcbk_seq.sv
sv/morse_callsign_beacon_keyer.sv
tb/morse_callsign_beacon_keyer_test.sv
